### rtl/clpm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the circular list pool manager
// no dependencies; used by circular_list_pool_manager

package clpm_pkg;

  typedef enum logic [1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_POP_FRONT = 2'd2,
    OP_CLEAR     = 2'd3
  } op_e;

  typedef struct packed {
    op_e         opcode;
    logic [31:0] value;
  } cmd_beat_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] data;
  } res_beat_t;

  localparam int unsigned POOL_W      = 9;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned REG_IDX_BIT = 2;
  localparam logic        REG_POOL_SIZE = 1'b0;

endpackage

### rtl/clpm_chan_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying one payload beat
// payload type is set at instantiation, normally a clpm_pkg beat struct

interface clpm_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/clpm_link_store.sv
`timescale 1ns / 1ps
// node link memory: one write and one registered read port
// nodes below the fresh watermark read as the initial descending free chain

module clpm_link_store #(
  parameter int unsigned NODES = 256,
  localparam int unsigned IDX_W = $clog2(NODES),
  localparam int unsigned LINK_W = $clog2(NODES + 1)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [LINK_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [IDX_W-1:0]  raddr_i,
  input  logic [LINK_W-1:0] fresh_i,
  output logic [LINK_W-1:0] rdata_o
);

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODES);

  logic [LINK_W-1:0] mem [NODES];
  logic [LINK_W-1:0] rdata_q;
  logic [IDX_W-1:0]  raddr_q;
  logic              fresh_hit_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q     <= mem[raddr_i];
      raddr_q     <= raddr_i;
      fresh_hit_q <= LINK_W'(raddr_i) < fresh_i;
    end
  end

  // untouched node: link to the next lower node, node 0 ends the chain
  always_comb begin
    if (!fresh_hit_q) begin
      rdata_o = rdata_q;
    end else if (raddr_q == '0) begin
      rdata_o = NULL_LINK;
    end else begin
      rdata_o = LINK_W'(raddr_q) - LINK_W'(1);
    end
  end

endmodule

### rtl/circular_list_pool_manager.sv
`timescale 1ns / 1ps
// circular singly linked list in a node pool with a free chain
// result: an accepted beat enters ST_EXEC, which registers it once no earlier result waits
// commands: the next beat is taken only back in ST_IDLE, after the link memory read then write-back
// reset: list empty, pool_size = min(NODES, 256); no clearing pass, untouched nodes
// follow a fill watermark; uses clpm_pkg, clpm_chan_if and clpm_link_store

module circular_list_pool_manager #(
  parameter int unsigned NODES     = 256,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  clpm_chan_if.sink                        cmd_i,
  clpm_chan_if.source                      res_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [clpm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int unsigned IDX_W    = $clog2(NODES);
  localparam int unsigned LINK_W   = $clog2(NODES + 1);
  localparam int unsigned WB       = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int unsigned POOL_RST = (NODES < 256) ? NODES : 256;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODES);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                       state_q;
  clpm_pkg::op_e                op_q;
  logic [LINK_W-1:0]            node_q;
  logic                         act_q;
  logic [IDX_W-1:0]             tail_q;
  logic [IDX_W-1:0]             head_q;
  logic                         empty_q;
  logic [LINK_W-1:0]            free_head_q;
  logic [LINK_W-1:0]            fresh_q;
  logic [clpm_pkg::POOL_W-1:0]  pool_size_q;
  logic [clpm_pkg::POOL_W-1:0]  pool_size_d;
  logic                         out_valid_q;
  logic                         out_ok_q;
  logic [31:0]                  out_data_q;

  logic              cmd_acc;
  logic              finish;
  logic              ins_ok;
  logic              cfg_wr;
  logic [IDX_W-1:0]  fh_idx;
  logic [IDX_W-1:0]  node_idx;

  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic              link_re;
  logic [IDX_W-1:0]  link_raddr;
  logic [LINK_W-1:0] link_rdata;

  logic              word_we;
  logic              word_re;
  logic [WB-1:0]     word_mem [NODES];
  logic [WB-1:0]     word_rdata_q;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign finish      = (state_q == ST_EXEC) && (!out_valid_q || res_o.ready);
  assign ins_ok      = (free_head_q != NULL_LINK);
  assign fh_idx      = free_head_q[IDX_W-1:0];
  assign node_idx    = node_q[IDX_W-1:0];

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = clpm_pkg::res_beat_t'{ok: out_ok_q, data: out_data_q};

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[clpm_pkg::REG_IDX_BIT] == clpm_pkg::REG_POOL_SIZE);
  assign prdata = (paddr[clpm_pkg::REG_IDX_BIT] == clpm_pkg::REG_POOL_SIZE) ?
                  32'(pool_size_q) : 32'd0;

  always_comb begin
    pool_size_d = pwdata[clpm_pkg::POOL_W-1:0];
    if (pool_size_d == '0) begin
      pool_size_d = clpm_pkg::POOL_W'(1);
    end else if (32'(pool_size_d) > NODES) begin
      pool_size_d = clpm_pkg::POOL_W'(NODES);
    end
  end

  // link memory: first access at accept, write-back when the beat finishes
  always_comb begin
    link_we    = 1'b0;
    link_waddr = tail_q;
    link_wdata = free_head_q;
    link_re    = 1'b0;
    link_raddr = head_q;
    word_we    = 1'b0;
    word_re    = 1'b0;
    if (cmd_acc) begin
      case (cmd_i.payload.opcode) inside
        clpm_pkg::OP_INS_FRONT, clpm_pkg::OP_INS_BACK: begin
          if (ins_ok) begin
            link_re    = 1'b1;
            link_raddr = fh_idx;
            link_we    = 1'b1;
            link_waddr = fh_idx;
            link_wdata = empty_q ? free_head_q : LINK_W'(head_q);
            word_we    = 1'b1;
          end
        end
        clpm_pkg::OP_POP_FRONT: begin
          if (!empty_q) begin
            link_re    = 1'b1;
            link_raddr = head_q;
            link_we    = 1'b1;
            link_waddr = head_q;
            link_wdata = free_head_q;
            word_re    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (finish && act_q) begin
      case (op_q) inside
        clpm_pkg::OP_INS_FRONT, clpm_pkg::OP_INS_BACK: begin
          link_we    = !empty_q;
          link_wdata = node_q;
        end
        clpm_pkg::OP_POP_FRONT: begin
          link_we    = (node_idx != tail_q);
          link_wdata = link_rdata;
        end
        default: begin
          link_we    = 1'b1;
          link_wdata = free_head_q;
        end
      endcase
    end
  end

  clpm_link_store #(
    .NODES (NODES)
  ) u_link_store (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .fresh_i (fresh_q),
    .rdata_o (link_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_mem[fh_idx] <= cmd_i.payload.value[WB-1:0];
    end
    if (word_re) begin
      word_rdata_q <= word_mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= clpm_pkg::OP_INS_FRONT;
      node_q      <= '0;
      act_q       <= 1'b0;
      tail_q      <= '0;
      head_q      <= '0;
      empty_q     <= 1'b1;
      free_head_q <= LINK_W'(POOL_RST - 1);
      fresh_q     <= LINK_W'(POOL_RST);
      pool_size_q <= clpm_pkg::POOL_W'(POOL_RST);
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_acc) begin
            state_q <= ST_EXEC;
            op_q    <= cmd_i.payload.opcode;
            if (cmd_i.payload.opcode == clpm_pkg::OP_POP_FRONT) begin
              node_q <= LINK_W'(head_q);
            end else begin
              node_q <= free_head_q;
            end
            if (cmd_i.payload.opcode == clpm_pkg::OP_INS_FRONT ||
                cmd_i.payload.opcode == clpm_pkg::OP_INS_BACK) begin
              act_q <= ins_ok;
            end else begin
              act_q <= !empty_q;
            end
          end
        end
        ST_EXEC: begin
          if (finish) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            out_ok_q    <= 1'b1;
            out_data_q  <= '0;
            case (op_q) inside
              clpm_pkg::OP_INS_FRONT, clpm_pkg::OP_INS_BACK: begin
                if (!act_q) begin
                  out_ok_q <= 1'b0;
                end else begin
                  free_head_q <= link_rdata;
                  if (node_q < fresh_q) begin
                    fresh_q <= node_q;
                  end
                  if (empty_q) begin
                    tail_q  <= node_idx;
                    head_q  <= node_idx;
                    empty_q <= 1'b0;
                  end else if (op_q == clpm_pkg::OP_INS_FRONT) begin
                    head_q <= node_idx;
                  end else begin
                    tail_q <= node_idx;
                  end
                end
              end
              clpm_pkg::OP_POP_FRONT: begin
                if (!act_q) begin
                  out_ok_q <= 1'b0;
                end else begin
                  if (node_idx == tail_q) begin
                    empty_q <= 1'b1;
                  end else begin
                    head_q <= link_rdata[IDX_W-1:0];
                  end
                  free_head_q <= node_q;
                  out_data_q  <= 32'(word_rdata_q);
                end
              end
              default: begin
                if (act_q) begin
                  free_head_q <= LINK_W'(head_q);
                  empty_q     <= 1'b1;
                end
              end
            endcase
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // pool_size write rebuilds the free chain and empties the list
      if (cfg_wr) begin
        pool_size_q <= pool_size_d;
        free_head_q <= LINK_W'(pool_size_d) - LINK_W'(1);
        fresh_q     <= LINK_W'(pool_size_d);
        tail_q      <= '0;
        empty_q     <= 1'b1;
      end
    end
  end

  a_accept_starts_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc |=> state_q == ST_EXEC)
    else $error("accepted beat did not enter execution");

  a_free_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= NULL_LINK)
    else $error("free chain head out of range");

  a_fresh_within_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= LINK_W'(pool_size_q))
    else $error("fill watermark above pool size");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result beat without execution");

  a_last_pop_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && op_q == clpm_pkg::OP_POP_FRONT && act_q && node_idx == tail_q)
      |=> empty_q)
    else $error("pop of last node left list non-empty");

endmodule
